/* hw/rtl/cst_pkg.sv */
// shared types and character constants for the comment skipping tokenizer
package cst_pkg;

	localparam logic [15:0] CH_CR     = 16'h000d;
	localparam logic [15:0] CH_LF     = 16'h000a;
	localparam logic [15:0] CH_TAB    = 16'h0009;
	localparam logic [15:0] CH_BS     = 16'h0008;
	localparam logic [15:0] CH_SPACE  = 16'h0020;
	localparam logic [15:0] CH_QUOTE  = 16'h0022;
	localparam logic [15:0] CH_PERIOD = 16'h002e;
	localparam logic [15:0] CH_COMMA  = 16'h002c;
	localparam logic [15:0] CH_SLASH  = 16'h002f;
	localparam logic [15:0] CH_STAR   = 16'h002a;

	localparam int unsigned MAX_RES = 3;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_SLASH  = 3'd1,
		MODE_LINE   = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_BSTAR  = 3'd4,
		MODE_WORD   = 3'd5,
		MODE_STRING = 3'd6
	} mode_t;

	typedef struct packed {
		logic [15:0] out_char;
		logic        char_valid;
		logic        token_start;
		logic        token_end;
		logic        is_quoted;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		mode_t                    next_mode;
		logic [1:0]               count;
		res_t [MAX_RES-1:0]       res;
	} lex_out_t;

	typedef struct packed {
		logic [1:0] count;
		logic       free;
	} obuf_stat_t;

endpackage

/* hw/rtl/comment_skipping_tokenizer.sv */
// top level of the comment skipping tokenizer
//
// channel   dir  tdata               tuser                                  tlast
// s_axis    in   code_unit[15:0]     -                                      end_of_text
// m_axis    out  out_char[15:0]      char_valid,token_start,token_end,      last_of_run
//                                    is_quoted (low bit first)
//
// one code unit per cycle when each unit gives at most one result and m_axis is not stalled
// a unit that gives several results holds the output until all are taken, the input waits meanwhile
// an accepted unit passes the input register, then the result buffer, before its first result
// reset returns the lexer to idle and empties both stages, no clearing pass
// either side may stall at any time without loss
module comment_skipping_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // code_unit
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_char
	output logic [3:0]  m_axis_tuser,  // char_valid, token_start, token_end, is_quoted
	output logic        m_axis_tlast
);

	logic                valid_s1;
	logic [15:0]         unit_s1;
	logic                eot_s1;
	cst_pkg::mode_t      mode_q;
	cst_pkg::lex_out_t   lex_out;
	cst_pkg::res_t       head;
	cst_pkg::obuf_stat_t stat;
	logic                consume;
	logic                in_take;

	assign consume = valid_s1 && stat.free;
	assign s_axis_tready = !valid_s1 || consume;
	assign in_take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			unit_s1 <= s_axis_tdata;
			eot_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cst_pkg::MODE_IDLE;
		end else if (consume) begin
			mode_q <= lex_out.next_mode;
		end
	end

	cst_lex u_lex (
		.mode        (mode_q),
		.code_unit   (unit_s1),
		.end_of_text (eot_s1),
		.lex_out     (lex_out)
	);

	cst_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_req   (valid_s1),
		.lex_out    (lex_out),
		.take       (m_axis_tready),
		.head       (head),
		.head_valid (m_axis_tvalid),
		.stat       (stat)
	);

	assign m_axis_tdata = head.out_char;
	assign m_axis_tuser = {head.is_quoted, head.token_end, head.token_start, head.char_valid};
	assign m_axis_tlast = head.last_of_run;

`ifndef ASSERT_OFF
	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && stat.count == 2'd1) |-> m_axis_tlast)
		else $error("final buffered result lacks last_of_run");

	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && stat.count != 2'd1) |-> !m_axis_tlast)
		else $error("last_of_run before the final result");

	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && eot_s1) |=> (mode_q == cst_pkg::MODE_IDLE))
		else $error("lexer not idle after end of text");

	a_zero_char: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'h0000))
		else $error("marker result carries a character");
`endif

endmodule

/* hw/rtl/cst_lex.sv */
// next-state and result generation for one code unit
module cst_lex (
	input  cst_pkg::mode_t    mode,
	input  logic [15:0]       code_unit,
	input  logic              end_of_text,
	output cst_pkg::lex_out_t lex_out
);

	function automatic cst_pkg::res_t mk(input logic [15:0] ch, input logic valid,
		input logic start, input logic stop, input logic quoted);
		cst_pkg::res_t r;
		r.out_char    = valid ? ch : 16'h0000;
		r.char_valid  = valid;
		r.token_start = start;
		r.token_end   = stop;
		r.is_quoted   = quoted;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	logic                  is_space;
	logic                  is_sep;
	logic                  do_word;
	logic [1:0]            n;
	cst_pkg::mode_t        nxt;
	cst_pkg::res_t [2:0]   res;

	assign is_space = (code_unit == cst_pkg::CH_SPACE) || (code_unit == cst_pkg::CH_CR) ||
		(code_unit == cst_pkg::CH_LF) || (code_unit == cst_pkg::CH_TAB) ||
		(code_unit == cst_pkg::CH_BS);
	assign is_sep = is_space || (code_unit == cst_pkg::CH_PERIOD) ||
		(code_unit == cst_pkg::CH_COMMA);

	always_comb begin
		n = 2'd0;
		nxt = mode;
		res = '0;
		do_word = 1'b0;
		case (mode)
			cst_pkg::MODE_SLASH: begin
				if (code_unit == cst_pkg::CH_SLASH) begin
					nxt = cst_pkg::MODE_LINE;
				end else if (code_unit == cst_pkg::CH_STAR) begin
					nxt = cst_pkg::MODE_BSTAR;
				end else begin
					res[n] = mk(cst_pkg::CH_SLASH, 1'b1, 1'b1, 1'b0, 1'b0);
					n = n + 2'd1;
					nxt = cst_pkg::MODE_WORD;
					do_word = 1'b1;
				end
			end
			cst_pkg::MODE_LINE: begin
				if (code_unit == cst_pkg::CH_CR)
					nxt = cst_pkg::MODE_IDLE;
			end
			cst_pkg::MODE_BLOCK: begin
				if (code_unit == cst_pkg::CH_STAR)
					nxt = cst_pkg::MODE_BSTAR;
			end
			cst_pkg::MODE_BSTAR: begin
				if (code_unit == cst_pkg::CH_SLASH)
					nxt = cst_pkg::MODE_IDLE;
				else if (code_unit != cst_pkg::CH_STAR)
					nxt = cst_pkg::MODE_BLOCK;
			end
			cst_pkg::MODE_WORD: begin
				do_word = 1'b1;
			end
			cst_pkg::MODE_STRING: begin
				if (code_unit == cst_pkg::CH_QUOTE || code_unit == cst_pkg::CH_CR ||
					code_unit == cst_pkg::CH_LF) begin
					res[n] = mk(16'h0000, 1'b0, 1'b0, 1'b1, 1'b1);
					n = n + 2'd1;
					nxt = cst_pkg::MODE_IDLE;
				end else begin
					res[n] = mk(code_unit, 1'b1, 1'b0, 1'b0, 1'b1);
					n = n + 2'd1;
				end
			end
			default: begin
				if (is_sep) begin
					nxt = cst_pkg::MODE_IDLE;
				end else if (code_unit == cst_pkg::CH_SLASH) begin
					nxt = cst_pkg::MODE_SLASH;
				end else if (code_unit == cst_pkg::CH_QUOTE) begin
					res[n] = mk(16'h0000, 1'b0, 1'b1, 1'b0, 1'b1);
					n = n + 2'd1;
					nxt = cst_pkg::MODE_STRING;
				end else begin
					res[n] = mk(code_unit, 1'b1, 1'b1, 1'b0, 1'b0);
					n = n + 2'd1;
					nxt = cst_pkg::MODE_WORD;
				end
			end
		endcase

		if (do_word) begin
			if (is_sep) begin
				res[n] = mk(16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
				n = n + 2'd1;
				nxt = cst_pkg::MODE_IDLE;
			end else if (code_unit == cst_pkg::CH_QUOTE) begin
				res[n] = mk(16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
				n = n + 2'd1;
				res[n] = mk(16'h0000, 1'b0, 1'b1, 1'b0, 1'b1);
				n = n + 2'd1;
				nxt = cst_pkg::MODE_STRING;
			end else begin
				res[n] = mk(code_unit, 1'b1, 1'b0, 1'b0, 1'b0);
				n = n + 2'd1;
			end
		end

		// end of text closes any open token
		if (end_of_text) begin
			if (nxt == cst_pkg::MODE_SLASH) begin
				res[n] = mk(cst_pkg::CH_SLASH, 1'b1, 1'b1, 1'b1, 1'b0);
				n = n + 2'd1;
			end else if (nxt == cst_pkg::MODE_WORD || nxt == cst_pkg::MODE_STRING) begin
				if (n != 2'd0) begin
					res[n - 2'd1].token_end = 1'b1;
				end else begin
					res[n] = mk(16'h0000, 1'b0, 1'b0, 1'b1, nxt == cst_pkg::MODE_STRING);
					n = n + 2'd1;
				end
			end
			nxt = cst_pkg::MODE_IDLE;
		end

		if (n != 2'd0)
			res[n - 2'd1].last_of_run = 1'b1;

		lex_out.next_mode = nxt;
		lex_out.count = n;
		lex_out.res = res;
	end

endmodule

/* hw/rtl/cst_obuf.sv */
// result buffer that hands out up to three results one per cycle while take is high
module cst_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_req,
	input  cst_pkg::lex_out_t   lex_out,
	input  logic                take,
	output cst_pkg::res_t       head,
	output logic                head_valid,
	output cst_pkg::obuf_stat_t stat
);

	logic [1:0]    cnt_q;
	cst_pkg::res_t res_q [cst_pkg::MAX_RES];
	logic          free;
	logic          load;
	logic          pop;

	assign pop = take && (cnt_q != 2'd0);
	assign free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign load = free && load_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= lex_out.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q[0] <= lex_out.res[0];
			res_q[1] <= lex_out.res[1];
			res_q[2] <= lex_out.res[2];
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	assign head = res_q[0];
	assign head_valid = (cnt_q != 2'd0);
	assign stat.count = cnt_q;
	assign stat.free = free;

endmodule
